@@ hw/rtl/gglt_pkg.sv @@
package gglt_pkg;

   localparam int LAT_W      = 31;
   localparam int LON_W      = 32;
   localparam int TIME_W     = 27;
   localparam int LAP_W      = 28;
   localparam int POINT_W    = 64;
   localparam int COORD_W    = 32;
   localparam int TOL_W      = 27;
   localparam int HOLD_W     = 16;
   localparam int MODE_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;
   localparam int MAX_EXITS  = 3;

   // window arithmetic: coordinate plus or minus tolerance, with sign and carry room
   localparam int WIN_W = COORD_W + 2;

   localparam int MODE_START_ONLY = 0;
   localparam int MODE_EXIT_BASE  = 1;

   localparam logic [MODE_W-1:0] TRACK_MODE_RESET = 4'd14;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_POINT    = 3'd0,
      REG_ENTRANCE_POINT = 3'd1,
      REG_EXIT_POINT_A   = 3'd2,
      REG_EXIT_POINT_B   = 3'd3,
      REG_EXIT_POINT_C   = 3'd4,
      REG_TOLERANCE      = 3'd5,
      REG_HOLDOFF        = 3'd6,
      REG_TRACK_MODE     = 3'd7
   } csr_index_type;

   typedef enum logic {
      END_START_FINISH = 1'b0,
      END_EXIT         = 1'b1
   } end_kind_type;

   typedef struct packed {
      logic [POINT_W-1:0] start_point;
      logic [POINT_W-1:0] entrance_point;
      logic [TOL_W-1:0]   tolerance;
      logic [HOLD_W-1:0]  holdoff;
      logic [MODE_W-1:0]  track_mode;
   } cfg_type;

endpackage

@@ hw/rtl/gglt_csr.sv @@
module gglt_csr #(
   parameter int NUM_EXITS = 3
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_we,
   input  logic [gglt_pkg::CSR_IDX_W-1:0]                csr_index,
   input  logic [gglt_pkg::CSR_DATA_W-1:0]               csr_wdata,
   output gglt_pkg::cfg_type                             cfg,
   output logic [NUM_EXITS-1:0][gglt_pkg::POINT_W-1:0]   exit_points
);

   localparam int IdxW   = gglt_pkg::CSR_IDX_W;
   localparam int CfgHiW = $bits(gglt_pkg::cfg_type) - gglt_pkg::MODE_W;

   gglt_pkg::cfg_type                            cfg_ff;
   gglt_pkg::cfg_type                            cfg_in;
   logic [NUM_EXITS-1:0][gglt_pkg::POINT_W-1:0]  exit_ff;
   logic [NUM_EXITS-1:0][gglt_pkg::POINT_W-1:0]  exit_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (gglt_pkg::csr_index_type'(csr_index))
            gglt_pkg::REG_START_POINT: begin
               cfg_in.start_point = csr_wdata;
            end
            gglt_pkg::REG_ENTRANCE_POINT: begin
               cfg_in.entrance_point = csr_wdata;
            end
            gglt_pkg::REG_TOLERANCE: begin
               cfg_in.tolerance = csr_wdata[gglt_pkg::TOL_W-1:0];
            end
            gglt_pkg::REG_HOLDOFF: begin
               cfg_in.holdoff = csr_wdata[gglt_pkg::HOLD_W-1:0];
            end
            gglt_pkg::REG_TRACK_MODE: begin
               cfg_in.track_mode = csr_wdata[gglt_pkg::MODE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      exit_in = exit_ff;
      for (int k = 0; k < NUM_EXITS; k++) begin
         if (csr_we && csr_index == IdxW'(int'(gglt_pkg::REG_EXIT_POINT_A) + k)) begin
            exit_in[k] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= {{CfgHiW{1'b0}}, gglt_pkg::TRACK_MODE_RESET};
         exit_ff <= '0;
      end else begin
         cfg_ff  <= cfg_in;
         exit_ff <= exit_in;
      end
   end

   assign cfg         = cfg_ff;
   assign exit_points = exit_ff;

endmodule

@@ hw/rtl/gglt_zone.sv @@
module gglt_zone (
   input  logic signed [gglt_pkg::LAT_W-1:0]   latitude,
   input  logic signed [gglt_pkg::LON_W-1:0]   longitude,
   input  logic        [gglt_pkg::POINT_W-1:0] point,
   input  logic        [gglt_pkg::TOL_W-1:0]   tolerance,
   output logic                                hit
);

   localparam int WinW = gglt_pkg::WIN_W;
   localparam int CW   = gglt_pkg::COORD_W;

   logic signed [WinW-1:0] lat_x;
   logic signed [WinW-1:0] lon_x;
   logic signed [WinW-1:0] plat_x;
   logic signed [WinW-1:0] plon_x;
   logic signed [WinW-1:0] tol_x;
   logic                   lat_ok;
   logic                   lon_ok;

   assign lat_x  = WinW'(latitude);
   assign lon_x  = WinW'(longitude);
   assign plat_x = WinW'(signed'(point[2*CW-1:CW]));
   assign plon_x = WinW'(signed'(point[CW-1:0]));
   assign tol_x  = signed'({{(WinW-gglt_pkg::TOL_W){1'b0}}, tolerance});

   // strict window on each axis
   assign lat_ok = (lat_x > plat_x - tol_x) && (lat_x < plat_x + tol_x);
   assign lon_ok = (lon_x > plon_x - tol_x) && (lon_x < plon_x + tol_x);
   assign hit    = lat_ok && lon_ok;

endmodule

@@ hw/rtl/gps_geofence_lap_timer.sv @@
// GPS geofence lap timer.
// req channel: one beat per GPS fix; req_tdata carries latitude, longitude
// and time of day. Each fix is tested against square windows around the
// start/finish line, the track entrance and the enabled track exits.
// rsp channel: one beat per completed lap, with lap time and lap start time
// in rsp_tdata and the end kind (start/finish or exit) in rsp_tuser. Fixes
// that close no lap produce no beat.
// csr port: write-only registers, each written at a rising edge with csr_we
// high; write them only while no fix is in flight.
// A fix accepted into the input register is evaluated there; its lap beat
// is registered in the result register. Throughput: one fix per cycle while
// result beats are taken, set by the single evaluation stage in between.
// Reset clears all session state and sets the registers to their defaults
// (track_mode enables all three exits, session mode).
// When rsp_tready is low with a beat pending, one more fix is held in the
// input register and req_tready drops until the result beat is taken.
module gps_geofence_lap_timer #(
   parameter int NUM_EXITS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // latitude [30:0], longitude [62:31], time_of_day_ms [89:63], zero pad
   input  logic [gglt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // lap_time_ms [27:0], lap_start_ms [54:28], zero pad
   output logic [gglt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // lap_end_kind [0]
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [gglt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gglt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LatW  = gglt_pkg::LAT_W;
   localparam int LonW  = gglt_pkg::LON_W;
   localparam int TimeW = gglt_pkg::TIME_W;
   localparam int LapW  = gglt_pkg::LAP_W;
   localparam int HoldW = gglt_pkg::HOLD_W;

   gglt_pkg::cfg_type                            cfg;
   logic [NUM_EXITS-1:0][gglt_pkg::POINT_W-1:0]  exit_points;

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic signed [LatW-1:0]   lat_ff;
   logic signed [LonW-1:0]   lon_ff;
   logic [TimeW-1:0]         tod_ff;
   logic                     s1_adv;
   logic                     req_take;

   logic                     in_session_ff;
   logic                     in_session_in;
   logic                     seen_first_ff;
   logic                     seen_first_in;
   logic [TimeW-1:0]         last_event_ff;
   logic [TimeW-1:0]         last_event_in;
   logic [HoldW-1:0]         holdoff_ff;
   logic [HoldW-1:0]         holdoff_in;

   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic [LapW-1:0]          lap_time_ff;
   logic [TimeW-1:0]         lap_start_ff;
   gglt_pkg::end_kind_type   end_kind_ff;

   logic                     start_hit;
   logic                     entr_hit;
   logic [NUM_EXITS-1:0]     exit_hit;
   logic [NUM_EXITS-1:0]     exit_en;
   logic                     exit_any;
   logic                     start_only;
   logic [TimeW-1:0]         began;
   logic signed [LapW-1:0]   diff;
   logic                     diff_pos;
   logic                     emit;
   gglt_pkg::end_kind_type   emit_kind;

   gglt_csr #(
      .NUM_EXITS (NUM_EXITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .exit_points (exit_points)
   );

   gglt_zone u_start_zone (
      .latitude  (lat_ff),
      .longitude (lon_ff),
      .point     (cfg.start_point),
      .tolerance (cfg.tolerance),
      .hit       (start_hit)
   );

   gglt_zone u_entr_zone (
      .latitude  (lat_ff),
      .longitude (lon_ff),
      .point     (cfg.entrance_point),
      .tolerance (cfg.tolerance),
      .hit       (entr_hit)
   );

   for (genvar k = 0; k < NUM_EXITS; k++) begin : g_exit
      gglt_zone u_exit_zone (
         .latitude  (lat_ff),
         .longitude (lon_ff),
         .point     (exit_points[k]),
         .tolerance (cfg.tolerance),
         .hit       (exit_hit[k])
      );
      assign exit_en[k] = cfg.track_mode[gglt_pkg::MODE_EXIT_BASE + k];
   end

   assign exit_any   = |(exit_hit & exit_en);
   assign start_only = cfg.track_mode[gglt_pkg::MODE_START_ONLY];

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;

   assign began    = seen_first_ff ? last_event_ff : tod_ff;
   assign diff     = signed'(LapW'(tod_ff)) - signed'(LapW'(began));
   assign diff_pos = !diff[LapW-1] && (diff != '0);

   always_comb begin
      in_session_in = in_session_ff;
      seen_first_in = seen_first_ff;
      last_event_in = last_event_ff;
      holdoff_in    = holdoff_ff;
      emit          = 1'b0;
      emit_kind     = gglt_pkg::END_START_FINISH;
      if (s1_adv) begin
         if (holdoff_ff != '0) begin
            holdoff_in = holdoff_ff - HoldW'(1);
         end else begin
            seen_first_in = 1'b1;
            last_event_in = began;
            if (!start_only && !in_session_ff) begin
               if (entr_hit) begin
                  in_session_in = 1'b1;
                  last_event_in = tod_ff;
                  holdoff_in    = cfg.holdoff;
               end
            end else if (start_hit) begin
               last_event_in = tod_ff;
               holdoff_in    = cfg.holdoff;
               emit          = diff_pos;
            end else if (!start_only && exit_any) begin
               in_session_in = 1'b0;
               last_event_in = tod_ff;
               holdoff_in    = cfg.holdoff;
               emit          = 1'b1;
               emit_kind     = gglt_pkg::END_EXIT;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         in_session_ff <= 1'b0;
         seen_first_ff <= 1'b0;
         last_event_ff <= '0;
         holdoff_ff    <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         in_session_ff <= in_session_in;
         seen_first_ff <= seen_first_in;
         last_event_ff <= last_event_in;
         holdoff_ff    <= holdoff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         lat_ff <= signed'(req_tdata[LatW-1:0]);
         lon_ff <= signed'(req_tdata[LatW+LonW-1:LatW]);
         tod_ff <= req_tdata[LatW+LonW+TimeW-1:LatW+LonW];
      end
      if (s1_adv && emit) begin
         lap_time_ff  <= diff;
         lap_start_ff <= began;
         end_kind_ff  <= emit_kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(gglt_pkg::RSP_DATA_W-LapW-TimeW){1'b0}}, lap_start_ff, lap_time_ff};
   assign rsp_tuser  = end_kind_ff;

`ifndef NO_ASSERTIONS
   a_sf_lap_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == gglt_pkg::END_START_FINISH |->
         !rsp_tdata[LapW-1] && rsp_tdata[LapW-1:0] != '0)
      else $error("start/finish lap beat with non-positive lap time");

   a_holdoff_silent: assert property (@(posedge clock) disable iff (reset)
      s1_adv && holdoff_ff != '0 |-> !emit && in_session_in == in_session_ff)
      else $error("fix inside holdoff changed session or produced a lap");

   a_session_close_emits: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(in_session_ff) |->
         rsp_tvalid && rsp_tuser == gglt_pkg::END_EXIT)
      else $error("session closed without an exit lap beat");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled without a pending result");
`endif

endmodule
